/* sv/epoch_seconds_to_calendar_unit_macros.svh */
// Assertion macros used by the controller of the calendar conversion unit.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");
`define ESC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ESC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ESC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/esc_pkg.sv */
// Types, constants and the month length table of the calendar conversion unit.
package esc_pkg;

    // Each constant division first drops the power-of-two factor of its divisor as a plain
    // shift. The odd part is then divided by multiplying with floor(2^k / divisor), where k is
    // the width of the shifted dividend. That estimate is never high and at most one short,
    // so a single compare and subtract finishes it.
    localparam logic [10:0] DAY_DIVISOR  = 11'd675;   // 86400 / 128
    localparam logic [10:0] HOUR_DIVISOR = 11'd225;   // 3600 / 16
    localparam logic [10:0] MIN_DIVISOR  = 11'd15;    // 60 / 4
    localparam logic [10:0] WEEK_DIVISOR = 11'd7;

    localparam logic [15:0] DAY_RECIP  = 16'd49710;   // 2^25 / 675
    localparam logic [5:0]  HOUR_RECIP = 6'd36;       // 2^13 / 225
    localparam logic [6:0]  MIN_RECIP  = 7'd68;       // 2^10 / 15
    localparam logic [13:0] WEEK_RECIP = 14'd9362;    // 2^16 / 7

    // Day 0 of the epoch was a Thursday.
    localparam logic [15:0] WEEKDAY_OFFSET = 16'd4;

    localparam logic [11:0] BASE_YEAR      = 12'd1970;
    localparam logic [6:0]  BASE_YEAR_M100 = 7'd70;
    localparam logic [6:0]  LAST_M100      = 7'd99;
    localparam logic [8:0]  BASE_YEAR_M400 = 9'd370;
    localparam logic [8:0]  LAST_M400      = 9'd399;
    localparam logic [3:0]  LAST_MONTH     = 4'd11;

    // Steps of one constant division.
    localparam logic [1:0] STEP_EST    = 2'd0;
    localparam logic [1:0] STEP_REM    = 2'd1;
    localparam logic [1:0] STEP_ADJUST = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DIV_DAY  = 8'b0000_0010,
        S_DIV_HOUR = 8'b0000_0100,
        S_DIV_MIN  = 8'b0000_1000,
        S_DIV_WEEK = 8'b0001_0000,
        S_YEAR     = 8'b0010_0000,
        S_MONTH    = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_EST,
        OP_REM,
        OP_ADJUST,
        OP_YEAR_STEP,
        OP_LOAD_MONTH,
        OP_MONTH_STEP,
        OP_LOAD_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_WEEK
    } t_div_sel;

    typedef struct packed {
        t_dp_op   op;
        t_div_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_status;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* sv/esc_dp.sv */
// Datapath of the calendar conversion unit: constant dividers, year and month walk, result register.
module esc_dp
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic [31:0] i_epoch_seconds,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [2:0]  o_weekday,
    output logic [11:0] o_year_number,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_day_of_year
);

    logic [31:0] r_secs;
    logic [15:0] r_q;
    logic [10:0] r_r;
    logic [15:0] r_days;
    logic [16:0] r_sod;
    logic [11:0] r_msec;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [2:0]  r_weekday;
    logic [11:0] r_year;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [3:0]  r_month;
    logic [8:0]  r_yday;

    logic [5:0]  r_o_second;
    logic [5:0]  r_o_minute;
    logic [4:0]  r_o_hour;
    logic [2:0]  r_o_weekday;
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_mday;
    logic [8:0]  r_o_yday;

    logic [40:0] w_day_prod;
    logic [18:0] w_hour_prod;
    logic [16:0] w_min_prod;
    logic [15:0] w_week_x;
    logic [29:0] w_week_prod;
    logic [24:0] w_x;
    logic [10:0] w_d;
    logic [15:0] w_est;
    logic [26:0] w_sub;
    logic        w_over;
    logic [10:0] w_rem;
    logic [15:0] w_quo;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;

    assign w_day_prod  = 41'(r_secs[31:7]) * 41'(DAY_RECIP);
    assign w_hour_prod = 19'(r_sod[16:4]) * 19'(HOUR_RECIP);
    assign w_min_prod  = 17'(r_msec[11:2]) * 17'(MIN_RECIP);
    assign w_week_x    = 16'(r_days + WEEKDAY_OFFSET);
    assign w_week_prod = 30'(w_week_x) * 30'(WEEK_RECIP);

    always_comb begin
        case (i_cmd.sel)
            DIV_DAY: begin
                w_x   = r_secs[31:7];
                w_d   = DAY_DIVISOR;
                w_est = w_day_prod[40:25];
            end
            DIV_HOUR: begin
                w_x   = {12'd0, r_sod[16:4]};
                w_d   = HOUR_DIVISOR;
                w_est = {10'd0, w_hour_prod[18:13]};
            end
            DIV_MIN: begin
                w_x   = {15'd0, r_msec[11:2]};
                w_d   = MIN_DIVISOR;
                w_est = {9'd0, w_min_prod[16:10]};
            end
            default: begin
                w_x   = {9'd0, w_week_x};
                w_d   = WEEK_DIVISOR;
                w_est = {2'd0, w_week_prod[29:16]};
            end
        endcase
    end

    // The remainder against the estimate lies below twice the divisor.
    assign w_sub  = {2'd0, w_x} - ({11'd0, r_q} * {16'd0, w_d});
    assign w_over = r_r >= w_d;
    assign w_rem  = w_over ? r_r - w_d : r_r;
    assign w_quo  = r_q + {15'd0, w_over};

    // The year remainders are carried as counters so the leap rule needs no divider.
    assign w_leap = (r_year[1:0] == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_month, w_leap);

    assign o_status.year_done  = r_days < {7'd0, w_ylen};
    assign o_status.month_done = (r_month == LAST_MONTH) || (r_days < {11'd0, w_mlen});

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_IN: begin
                r_secs <= i_epoch_seconds;
                r_year <= BASE_YEAR;
                r_y100 <= BASE_YEAR_M100;
                r_y400 <= BASE_YEAR_M400;
            end
            OP_EST: begin
                r_q <= w_est;
            end
            OP_REM: begin
                r_r <= w_sub[10:0];
            end
            OP_ADJUST: begin
                // The bits shifted off the dividend go back below the remainder.
                case (i_cmd.sel)
                    DIV_DAY: begin
                        r_days <= w_quo;
                        r_sod  <= {w_rem[9:0], r_secs[6:0]};
                    end
                    DIV_HOUR: begin
                        r_hour <= w_quo[4:0];
                        r_msec <= {w_rem[7:0], r_sod[3:0]};
                    end
                    DIV_MIN: begin
                        r_minute <= w_quo[5:0];
                        r_second <= {w_rem[3:0], r_msec[1:0]};
                    end
                    default: begin
                        r_weekday <= w_rem[2:0];
                    end
                endcase
            end
            OP_YEAR_STEP: begin
                r_days <= r_days - {7'd0, w_ylen};
                r_year <= r_year + 12'd1;
                r_y100 <= (r_y100 == LAST_M100) ? 7'd0 : r_y100 + 7'd1;
                r_y400 <= (r_y400 == LAST_M400) ? 9'd0 : r_y400 + 9'd1;
            end
            OP_LOAD_MONTH: begin
                r_yday  <= r_days[8:0];
                r_month <= 4'd0;
            end
            OP_MONTH_STEP: begin
                r_days  <= r_days - {11'd0, w_mlen};
                r_month <= r_month + 4'd1;
            end
            OP_LOAD_OUT: begin
                r_o_second  <= r_second;
                r_o_minute  <= r_minute;
                r_o_hour    <= r_hour;
                r_o_weekday <= r_weekday;
                r_o_year    <= r_year;
                r_o_month   <= r_month + 4'd1;
                r_o_mday    <= r_days[4:0] + 5'd1;
                r_o_yday    <= r_yday;
            end
            default: begin
            end
        endcase
    end

    assign o_second_of_minute = r_o_second;
    assign o_minute_of_hour   = r_o_minute;
    assign o_hour_of_day      = r_o_hour;
    assign o_weekday          = r_o_weekday;
    assign o_year_number      = r_o_year;
    assign o_month_number     = r_o_month;
    assign o_day_of_month     = r_o_mday;
    assign o_day_of_year      = r_o_yday;

endmodule

/* sv/esc_ctrl.sv */
// Controller of the calendar conversion unit: sequencing, step counting and handshakes.
`include "epoch_seconds_to_calendar_unit_macros.svh"
module esc_ctrl
    import esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    function automatic t_dp_op div_op(input logic [1:0] step);
        t_dp_op op;
        unique case (step)
            STEP_EST: op = OP_EST;
            STEP_REM: op = OP_REM;
            default:  op = OP_ADJUST;
        endcase
        return op;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = DIV_DAY;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD_IN;
                    n_cnt    = STEP_EST;
                    n_state  = S_DIV_DAY;
                end
            end
            S_DIV_DAY: begin
                o_cmd.sel = DIV_DAY;
                o_cmd.op  = div_op(r_cnt);
                if (r_cnt == STEP_ADJUST) begin
                    n_cnt   = STEP_EST;
                    n_state = S_DIV_HOUR;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_DIV_HOUR: begin
                o_cmd.sel = DIV_HOUR;
                o_cmd.op  = div_op(r_cnt);
                if (r_cnt == STEP_ADJUST) begin
                    n_cnt   = STEP_EST;
                    n_state = S_DIV_MIN;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_DIV_MIN: begin
                o_cmd.sel = DIV_MIN;
                o_cmd.op  = div_op(r_cnt);
                if (r_cnt == STEP_ADJUST) begin
                    n_cnt   = STEP_EST;
                    n_state = S_DIV_WEEK;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_DIV_WEEK: begin
                o_cmd.sel = DIV_WEEK;
                o_cmd.op  = div_op(r_cnt);
                if (r_cnt == STEP_ADJUST) begin
                    n_cnt   = STEP_EST;
                    n_state = S_YEAR;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_YEAR: begin
                if (i_status.year_done) begin
                    o_cmd.op = OP_LOAD_MONTH;
                    n_state  = S_MONTH;
                end else begin
                    o_cmd.op = OP_YEAR_STEP;
                end
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = OP_MONTH_STEP;
                end
            end
            S_FINISH: begin
                // The result register may still hold the previous beat.
                if (!r_out_valid || i_ready) begin
                    o_cmd.op    = OP_LOAD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= STEP_EST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `ESC_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, o_cmd.op == OP_LOAD_OUT, !r_out_valid || i_ready)
    `ESC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_DIV_DAY)
    `ESC_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= STEP_ADJUST)
    `ESC_ASSERT_IMPLIES(a_valid_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FINISH)

endmodule

/* sv/epoch_seconds_to_calendar_unit.sv */
// Top level of the epoch seconds to Gregorian calendar conversion unit.
// Converts one 32-bit count of seconds since 1970-01-01 00:00:00 UTC at a time into second,
// minute, hour, weekday, year, month, day of month and zero-based day of year. The day, hour,
// minute and weekday splits are constant divisions, each done as a reciprocal estimate, its
// remainder and a final compare and subtract. Years are then stepped off one per cycle and
// months one per cycle, and a final step loads the result register once it is free. The year
// output runs from 1970 to 2106. A new beat is taken the cycle after the previous item has
// reached the result register, which holds it until taken; while it is still waiting the
// next item stalls before that register.
module epoch_seconds_to_calendar_unit
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [2:0]  o_weekday,
    output logic [11:0] o_year_number,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_day_of_year
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    esc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    esc_dp u_dp (
        .i_clk              (i_clk),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_weekday          (o_weekday),
        .o_year_number      (o_year_number),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month),
        .o_day_of_year      (o_day_of_year)
    );

endmodule
